// ===== hw/rtl/iiel_pkg.sv =====
// Shared types and constants for the indexed insert/erase list.
package iiel_pkg;

    localparam int DEPTH       = 16;
    localparam int WORD_WIDTH  = 32;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int LEN_W       = $clog2(DEPTH + 1);

    localparam int FUNC_W      = 2;
    localparam int IDX_W       = 5;
    localparam int VALUE_W     = 32;
    localparam int LEN_FIELD_W = 5;
    localparam int CMP_W       = (LEN_W > IDX_W) ? LEN_W : IDX_W;

    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_ERASE  = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [IDX_W-1:0]   index;
        logic [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic                   ok;
        logic [VALUE_W-1:0]     read_value;
        logic [LEN_FIELD_W-1:0] length;
    } rsp_t;

endpackage

// ===== hw/rtl/indexed_insert_erase_list.sv =====
// From accept to rsp_valid: a read or rejected beat registers its result directly; a write
// goes through S_PLACE; insert/erase go through S_READ and S_MOVE for each moved word, then
// S_PLACE; each moved word is one RAM read, then one RAM write.
// Throughput: one beat at a time; req_ready returns the cycle after the result is taken.
// Reset: rst_n asynchronous, active low; clears the length and the sequencer.
// Store contents are not cleared and hold whatever was last written.
module indexed_insert_erase_list (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  iiel_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output iiel_pkg::rsp_t rsp
);
    import iiel_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_MOVE  = 4'b0100,
        S_PLACE = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    logic [FUNC_W-1:0]   func_reg,  func_next;
    logic [LEN_W-1:0]    ptr_reg,   ptr_next;
    logic [IDX_W-1:0]    index_reg, index_next;
    logic [VALUE_W-1:0]  value_reg, value_next;
    logic [LEN_W-1:0]    len_reg,   len_next;
    logic                ok_reg,    ok_next;

    logic [WORD_WIDTH-1:0] mem [DEPTH];
    logic [WORD_WIDTH-1:0] mem_q;

    logic                  re;
    logic [ADDR_W-1:0]     raddr;
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [WORD_WIDTH-1:0] wdata;

    logic             accept;
    logic [CMP_W-1:0] idx_c;
    logic [CMP_W-1:0] len_c;
    logic             legal;
    logic [LEN_W-1:0] step_ptr;
    logic [LEN_W-1:0] ptr_init;
    logic [LEN_W-1:0] src_ptr;

    assign req_ready = (state_reg == S_IDLE) && !done_reg;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = done_reg;

    assign idx_c = CMP_W'(req.index);
    assign len_c = CMP_W'(len_reg);

    // Shared pointer step: insert walks down from the tail, erase walks up.
    assign step_ptr = (func_reg == FUNC_INSERT) ? (ptr_reg - LEN_W'(1))
                                                : (ptr_reg + LEN_W'(1));
    assign src_ptr  = step_ptr;
    assign ptr_init = (req.func == FUNC_INSERT) ? len_reg : LEN_W'(req.index);

    function automatic logic more_moves(input logic [FUNC_W-1:0] f,
                                        input logic [LEN_W-1:0]  p,
                                        input logic [IDX_W-1:0]  ix,
                                        input logic [LEN_W-1:0]  ln);
        logic r;
        r = 1'b0;
        if (f == FUNC_INSERT)
        begin
            r = CMP_W'(p) > CMP_W'(ix);
        end
        else if (f == FUNC_ERASE)
        begin
            r = (CMP_W'(p) + CMP_W'(1)) < CMP_W'(ln);
        end
        return r;
    endfunction

    always_comb
    begin
        case (req.func)
            FUNC_READ:   legal = idx_c < len_c;
            FUNC_WRITE:  legal = idx_c < len_c;
            FUNC_INSERT: legal = (idx_c <= len_c) && (len_c < CMP_W'(DEPTH));
            FUNC_ERASE:  legal = idx_c < len_c;
            default:     legal = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = done_reg;
        func_next  = func_reg;
        ptr_next   = ptr_reg;
        index_next = index_reg;
        value_next = value_reg;
        len_next   = len_reg;
        ok_next    = ok_reg;
        re         = 1'b0;
        raddr      = ptr_reg[ADDR_W-1:0];
        we         = 1'b0;
        waddr      = ptr_reg[ADDR_W-1:0];
        wdata      = WORD_WIDTH'(value_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (done_reg)
                begin
                    // hold the result until the beat is taken
                    if (rsp_ready)
                    begin
                        done_next = 1'b0;
                    end
                end
                else if (accept)
                begin
                    func_next  = req.func;
                    index_next = req.index;
                    value_next = req.value;
                    ptr_next   = ptr_init;
                    ok_next    = legal;
                    if (!legal)
                    begin
                        done_next = 1'b1;
                    end
                    else if (req.func == FUNC_READ)
                    begin
                        re        = 1'b1;
                        raddr     = req.index[ADDR_W-1:0];
                        done_next = 1'b1;
                    end
                    else if (more_moves(req.func, ptr_init, req.index, len_reg))
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_PLACE;
                    end
                end
            end
            S_READ:
            begin
                re         = 1'b1;
                raddr      = src_ptr[ADDR_W-1:0];
                state_next = S_MOVE;
            end
            S_MOVE:
            begin
                we       = 1'b1;
                wdata    = mem_q;
                ptr_next = step_ptr;
                if (more_moves(func_reg, step_ptr, index_reg, len_reg))
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                if (func_reg != FUNC_ERASE)
                begin
                    we = 1'b1;
                end
                if (func_reg == FUNC_INSERT)
                begin
                    len_next = len_reg + LEN_W'(1);
                end
                else if (func_reg == FUNC_ERASE)
                begin
                    len_next = len_reg - LEN_W'(1);
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            len_reg   <= '0;
            func_reg  <= FUNC_READ;
            ptr_reg   <= '0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            len_reg   <= len_next;
            func_reg  <= func_next;
            ptr_reg   <= ptr_next;
            ok_reg    <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        index_reg <= index_next;
        value_reg <= value_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            mem_q <= mem[raddr];
        end
    end

    assign rsp.ok         = ok_reg;
    assign rsp.read_value = (ok_reg && func_reg == FUNC_READ) ? VALUE_W'(mem_q) : '0;
    assign rsp.length     = LEN_FIELD_W'(len_reg);

    a_busy_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("request taken while a result is pending");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(len_reg) <= CMP_W'(DEPTH))
        else $error("list length beyond depth");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> CMP_W'(ptr_reg) < CMP_W'(DEPTH))
        else $error("store write pointer out of range");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("ready not dropped after accept");

    a_len_stable_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.ok) |-> $stable(len_reg))
        else $error("length changed on a rejected beat");

endmodule

// ===== sim/tb_indexed_insert_erase_list.sv =====
// Testbench for indexed_insert_erase_list: directed table, then random beats against a predictor.
module tb_indexed_insert_erase_list;

    import iiel_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 60;
    localparam int PHASE_BEATS    = 330;
    localparam int HOLD_CYCLES    = 300;
    localparam int DIR_ROWS       = 22;
    localparam rsp_t NO_RSP       = '0;

    typedef struct {
        logic [FUNC_W-1:0]  func;
        logic [IDX_W-1:0]   index;
        logic [VALUE_W-1:0] value;
        int                 reps;
        bit                 typed;
        rsp_t               want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // predictor state
    logic [WORD_WIDTH-1:0] list_words [DEPTH];
    int                    list_len;
    rsp_t                  pending_rsp_q [$];

    int   mismatches;
    int   send_idle_pct;
    int   rsp_stall_pct;
    int   hold_len;
    int   quiet_cycles;
    rsp_t head_rsp;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{FUNC_READ,   5'd0,  32'h0000_0000, 1,  1'b1, '{1'b0, 32'h0, 5'd0}},
        '{FUNC_ERASE,  5'd0,  32'h0000_0000, 1,  1'b1, '{1'b0, 32'h0, 5'd0}},
        '{FUNC_WRITE,  5'd0,  32'hFFFF_FFFF, 1,  1'b1, '{1'b0, 32'h0, 5'd0}},
        '{FUNC_INSERT, 5'd1,  32'h0000_0000, 1,  1'b1, '{1'b0, 32'h0, 5'd0}},
        '{FUNC_READ,   5'd31, 32'h0000_0000, 1,  1'b1, '{1'b0, 32'h0, 5'd0}},
        '{FUNC_INSERT, 5'd0,  32'hFFFF_FFFF, 1,  1'b1, '{1'b1, 32'h0, 5'd1}},
        '{FUNC_READ,   5'd0,  32'h0000_0000, 1,  1'b1, '{1'b1, 32'hFFFF_FFFF, 5'd1}},
        '{FUNC_INSERT, 5'd1,  32'h0000_0000, 1,  1'b1, '{1'b1, 32'h0, 5'd2}},
        '{FUNC_INSERT, 5'd1,  32'hA5A5_A5A5, 1,  1'b0, NO_RSP},
        '{FUNC_READ,   5'd2,  32'h0000_0000, 1,  1'b0, NO_RSP},
        '{FUNC_ERASE,  5'd0,  32'h0000_0000, 1,  1'b0, NO_RSP},
        '{FUNC_INSERT, 5'd0,  32'h5A5A_5A5A, 14, 1'b0, NO_RSP},
        '{FUNC_INSERT, 5'd0,  32'h0000_0000, 1,  1'b1, '{1'b0, 32'h0, 5'd16}},
        '{FUNC_INSERT, 5'd16, 32'hFFFF_FFFF, 1,  1'b1, '{1'b0, 32'h0, 5'd16}},
        '{FUNC_READ,   5'd15, 32'h0000_0000, 1,  1'b0, NO_RSP},
        '{FUNC_READ,   5'd16, 32'h0000_0000, 1,  1'b1, '{1'b0, 32'h0, 5'd16}},
        '{FUNC_WRITE,  5'd15, 32'hFFFF_FFFF, 1,  1'b1, '{1'b1, 32'h0, 5'd16}},
        '{FUNC_READ,   5'd15, 32'h0000_0000, 1,  1'b1, '{1'b1, 32'hFFFF_FFFF, 5'd16}},
        '{FUNC_ERASE,  5'd16, 32'h0000_0000, 1,  1'b1, '{1'b0, 32'h0, 5'd16}},
        '{FUNC_ERASE,  5'd15, 32'h0000_0000, 1,  1'b1, '{1'b1, 32'h0, 5'd15}},
        '{FUNC_READ,   5'd15, 32'h0000_0000, 1,  1'b1, '{1'b0, 32'h0, 5'd15}},
        '{FUNC_ERASE,  5'd0,  32'h0000_0000, 1,  1'b0, NO_RSP}
    };

    indexed_insert_erase_list dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ERROR %s", $time, msg);
        mismatches++;
    endtask

    // Apply one operation to the shadow list and return the result it should give.
    function automatic rsp_t apply_list_op(input req_t beat);
        rsp_t r;
        int   idx;
        int   i;
        r   = '0;
        idx = int'(beat.index);
        case (beat.func)
            FUNC_READ:
                if (idx < list_len)
                begin
                    r.ok         = 1'b1;
                    r.read_value = list_words[idx];
                end
            FUNC_WRITE:
                if (idx < list_len)
                begin
                    list_words[idx] = beat.value;
                    r.ok            = 1'b1;
                end
            FUNC_INSERT:
                if (idx <= list_len && list_len < DEPTH)
                begin
                    for (i = list_len; i > idx; i--)
                        list_words[i] = list_words[i-1];
                    list_words[idx] = beat.value;
                    list_len++;
                    r.ok = 1'b1;
                end
            FUNC_ERASE:
                if (idx < list_len)
                begin
                    for (i = idx; i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                    r.ok = 1'b1;
                end
            default:
                r.ok = 1'b0;
        endcase
        r.length = list_len[LEN_FIELD_W-1:0];
        return r;
    endfunction

    // Offer one beat, hold it until accepted, then log its expected result.
    task automatic send_beat(input req_t beat, input bit typed, input rsp_t want);
        rsp_t predicted;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        req       <= beat;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_ready !== 1'b1);
        predicted = apply_list_op(beat);
        pending_rsp_q.push_back(typed ? want : predicted);
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_len != 0)
            begin
                rsp_ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
            end
            else
                rsp_ready <= (rsp_stall_pct == 0) || ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rsp_valid === 1'b1 && rsp_ready === 1'b1)
        begin
            if (pending_rsp_q.size() == 0)
                report_mismatch($sformatf("result beat with nothing pending: %h", rsp));
            else
            begin
                head_rsp = pending_rsp_q.pop_front();
                if (rsp.ok !== head_rsp.ok)
                    report_mismatch($sformatf("ok %b, want %b", rsp.ok, head_rsp.ok));
                if (rsp.read_value !== head_rsp.read_value)
                    report_mismatch($sformatf("read_value %h, want %h",
                                              rsp.read_value, head_rsp.read_value));
                if (rsp.length !== head_rsp.length)
                    report_mismatch($sformatf("length %0d, want %0d",
                                              rsp.length, head_rsp.length));
            end
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid === 1'b1 && req_ready === 1'b1) ||
                (rsp_valid === 1'b1 && rsp_ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t watchdog expired, %0d results outstanding", $time, pending_rsp_q.size());
        $display("** indexed_insert_erase_list: FAILED **");
        $finish;
    end

    initial
    begin
        req_t beat;
        int   r;
        int   k;
        int   ph;
        int   n;
        int   pick;
        bit   filling;

        mismatches    = 0;
        list_len      = 0;
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        hold_len      = 0;
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < DIR_ROWS; r++)
            for (k = 0; k < dir_rows[r].reps; k++)
            begin
                beat.func  = dir_rows[r].func;
                beat.index = dir_rows[r].index;
                beat.value = dir_rows[r].value + VALUE_W'(k);
                send_beat(beat, dir_rows[r].typed, dir_rows[r].want);
            end

        filling = 1'b1;
        for (ph = 0; ph < 5; ph++)
        begin
            case (ph)
                1: begin send_idle_pct = 63; rsp_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rsp_stall_pct = 63; end
                3: begin send_idle_pct = 33; rsp_stall_pct = 33; end
                default: begin send_idle_pct = 0; rsp_stall_pct = 0; end
            endcase
            for (n = 0; n < PHASE_BEATS; n++)
            begin
                if (ph == 4 && n == 20)
                    hold_len = HOLD_CYCLES;
                if (ph == 1 && n == 150)
                    drain_results();

                // sweep the length between empty and full
                if (list_len == DEPTH)
                    filling = 1'b0;
                else if (list_len == 0)
                    filling = 1'b1;
                else if ($urandom_range(29) == 0)
                    filling = !filling;

                pick = $urandom_range(99);
                if (pick < 45)
                    beat.func = filling ? FUNC_INSERT : FUNC_ERASE;
                else if (pick < 65)
                    beat.func = filling ? FUNC_ERASE : FUNC_INSERT;
                else if (pick < 85)
                    beat.func = FUNC_READ;
                else
                    beat.func = FUNC_WRITE;

                if ($urandom_range(99) < 20)
                    beat.index = IDX_W'($urandom_range(31));
                else if (beat.func == FUNC_INSERT)
                    beat.index = IDX_W'($urandom_range(list_len));
                else
                    beat.index = (list_len == 0) ? '0 : IDX_W'($urandom_range(list_len - 1));

                pick = $urandom_range(9);
                if (pick == 0)
                    beat.value = '0;
                else if (pick == 1)
                    beat.value = '1;
                else
                    beat.value = $urandom;

                send_beat(beat, 1'b0, NO_RSP);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("** indexed_insert_erase_list: PASSED **");
        else
            $display("** indexed_insert_erase_list: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/iiel_pkg.sv
hw/rtl/indexed_insert_erase_list.sv
sim/tb_indexed_insert_erase_list.sv
